/* hw/rtl/variable_speed_sample_player_unit_defines.svh */
// Assertion macros for the variable speed sample player.
// Included by the modules that check their own logic; depends on clk and rst in scope.
`ifndef VARIABLE_SPEED_SAMPLE_PLAYER_UNIT_DEFINES_SVH
`define VARIABLE_SPEED_SAMPLE_PLAYER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VSSP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("vssp check failed");
`define VSSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vssp sequence check failed");
`else
`define VSSP_ASSERT(label, cond)
`define VSSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/vssp_pkg.sv */
// Shared types, codes and constants of the variable speed sample player.
// No dependencies.
package vssp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAME_BITS  = 16;
  localparam int POS_BITS    = 17;
  localparam int FRAC_BITS   = 10;
  localparam int BANK_BITS   = FRAME_BITS - 1;
  localparam int NUM_BITS    = 27;
  localparam int MAG_BITS    = 25;
  localparam int RECIP_BITS  = 26;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

  localparam logic [POS_BITS-1:0]   TOTAL_MAX  = 17'd65536;
  localparam logic [POS_BITS-1:0]   CURSOR_MAX = 17'h1FFFF;
  localparam logic [FRAC_BITS-1:0]  SPEED_MIN  = 10'd100;
  localparam logic [FRAC_BITS-1:0]  SPEED_MAX  = 10'd1000;
  localparam logic [FRAC_BITS:0]    FRAC_ONE   = 11'd1000;
  localparam logic [RECIP_BITS-1:0] RECIP_K    = 26'd34359739;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PLAY  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] REG_SPEED     = 2'd0;
  localparam logic [1:0] REG_TOTAL     = 2'd1;
  localparam logic [1:0] REG_SRC_CHANS = 2'd2;
  localparam logic [1:0] REG_OUT_CHANS = 2'd3;

  typedef struct packed {
    logic                reached;
    logic                playing;
    logic [POS_BITS-1:0] snap;
  } vssp_status_t;

  typedef struct packed {
    logic                 active;
    logic                 use_next;
    logic                 fl_odd;
    logic                 src2;
    logic                 out2;
    logic [FRAC_BITS-1:0] frac;
    vssp_status_t         status;
  } vssp_tick_t;

  typedef struct packed {
    logic                          we;
    logic [FRAME_BITS-1:0]         frame;
    logic                          chan;
    logic signed [SAMPLE_BITS-1:0] value;
  } vssp_wr_t;

  typedef struct packed {
    logic                 re;
    logic [BANK_BITS-1:0] even_addr;
    logic [BANK_BITS-1:0] odd_addr;
  } vssp_rd_t;

endpackage

/* hw/rtl/vssp_store.sv */
// Sample store: even and odd frame banks, both channels in one word.
// Depends on vssp_pkg.
module vssp_store (
  input  logic                              clk,
  input  vssp_pkg::vssp_wr_t                wr,
  input  vssp_pkg::vssp_rd_t                rd,
  output logic [2*vssp_pkg::SAMPLE_BITS-1:0] even_q,
  output logic [2*vssp_pkg::SAMPLE_BITS-1:0] odd_q
);
  import vssp_pkg::*;

  localparam int DEPTH = 1 << BANK_BITS;

  logic [2*SAMPLE_BITS-1:0] even_mem [0:DEPTH-1];
  logic [2*SAMPLE_BITS-1:0] odd_mem  [0:DEPTH-1];
  logic [BANK_BITS-1:0]     wr_addr;

  assign wr_addr = wr.frame[FRAME_BITS-1:1];

  always_ff @(posedge clk) begin
    if (wr.we && !wr.frame[0]) begin
      if (wr.chan) begin
        even_mem[wr_addr][2*SAMPLE_BITS-1:SAMPLE_BITS] <= wr.value;
      end else begin
        even_mem[wr_addr][SAMPLE_BITS-1:0] <= wr.value;
      end
    end
    if (rd.re) begin
      even_q <= even_mem[rd.even_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.frame[0]) begin
      if (wr.chan) begin
        odd_mem[wr_addr][2*SAMPLE_BITS-1:SAMPLE_BITS] <= wr.value;
      end else begin
        odd_mem[wr_addr][SAMPLE_BITS-1:0] <= wr.value;
      end
    end
    if (rd.re) begin
      odd_q <= odd_mem[rd.odd_addr];
    end
  end

endmodule

/* hw/rtl/vssp_interp.sv */
// Three-stage interpolator: 1000*a + f*(b-a), round half away, divide by 1000.
// Depends on vssp_pkg.
module vssp_interp (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [vssp_pkg::SAMPLE_BITS-1:0] a,
  input  logic signed [vssp_pkg::SAMPLE_BITS-1:0] b,
  input  logic [vssp_pkg::FRAC_BITS-1:0]       frac,
  output logic signed [vssp_pkg::SAMPLE_BITS-1:0] res
);
  import vssp_pkg::*;

  logic signed [NUM_BITS-1:0] a_x;
  logic signed [NUM_BITS-1:0] diff;
  logic signed [NUM_BITS-1:0] frac_s;
  logic signed [NUM_BITS-1:0] base;
  logic signed [NUM_BITS-1:0] prod;
  logic signed [NUM_BITS-1:0] num;
  logic signed [NUM_BITS-1:0] pos_round;
  logic signed [NUM_BITS-1:0] neg_round;
  logic [MAG_BITS-1:0]        mag;
  logic                       neg_b;
  logic [PROD_BITS-1:0]       prodk;
  logic [SAMPLE_BITS-1:0]     q;
  logic                       neg_c;

  assign a_x    = NUM_BITS'(a);
  assign diff   = NUM_BITS'(b) - NUM_BITS'(a);
  assign frac_s = $signed({{(NUM_BITS-FRAC_BITS){1'b0}}, frac});

  always_ff @(posedge clk) begin
    if (en) begin
      base <= a_x * 27'sd1000;
      prod <= diff * frac_s;
    end
  end

  assign num       = base + prod;
  assign pos_round = num + 27'sd500;
  assign neg_round = 27'sd500 - num;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= num[NUM_BITS-1];
      mag   <= num[NUM_BITS-1] ? neg_round[MAG_BITS-1:0] : pos_round[MAG_BITS-1:0];
    end
  end

  assign prodk = PROD_BITS'(mag) * PROD_BITS'(RECIP_K);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_c <= neg_b;
      q     <= prodk[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT];
    end
  end

  assign res = neg_c ? $signed(SAMPLE_BITS'(0 - q)) : $signed(q);

endmodule

/* hw/rtl/vssp_ctrl.sv */
// Configuration registers, cursor and play state; decodes each request.
// Depends on vssp_pkg and the assertion macro header.
`include "variable_speed_sample_player_unit_defines.svh"
module vssp_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [1:0]                          cfg_index,
  input  logic [vssp_pkg::POS_BITS-1:0]       cfg_data,
  input  logic                                acc,
  input  logic [1:0]                          opcode,
  input  logic [vssp_pkg::FRAME_BITS-1:0]     frame_index,
  input  logic                                channel_index,
  input  logic signed [vssp_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic [vssp_pkg::POS_BITS-1:0]       start_position,
  input  logic [vssp_pkg::POS_BITS-1:0]       end_position,
  output vssp_pkg::vssp_wr_t                  wr,
  output vssp_pkg::vssp_rd_t                  rd,
  output vssp_pkg::vssp_tick_t                tick
);
  import vssp_pkg::*;

  logic [FRAC_BITS-1:0] speed;
  logic [POS_BITS-1:0]  total;
  logic [1:0]           src_chans;
  logic [1:0]           out_chans;
  logic [POS_BITS-1:0]  cursor_whole;
  logic [FRAC_BITS-1:0] cursor_frac;
  logic [POS_BITS-1:0]  range_end;
  logic                 playing;

  logic [POS_BITS-1:0]  total_eff;
  logic [FRAC_BITS-1:0] speed_eff;
  logic [POS_BITS:0]    nx;
  logic                 ended;
  logic                 next_ok;
  logic [FRAC_BITS:0]   frac_sum;
  logic                 carry;
  logic [FRAC_BITS:0]   frac_wrap;
  logic [FRAC_BITS-1:0] frac_adv;
  logic [POS_BITS-1:0]  whole_adv;
  logic [POS_BITS-1:0]  whole_after;
  logic [POS_BITS-1:0]  snap_a;
  logic [POS_BITS-1:0]  end_clamped;
  logic                 play_ok;
  logic [FRAME_BITS-1:0] fl16;

  assign total_eff = (total > TOTAL_MAX) ? TOTAL_MAX : total;
  assign speed_eff = (speed < SPEED_MIN) ? SPEED_MIN : ((speed > SPEED_MAX) ? SPEED_MAX : speed);

  assign nx      = {1'b0, cursor_whole} + 18'd1;
  assign ended   = (cursor_whole >= range_end) || (cursor_whole >= total_eff);
  assign next_ok = (nx < {1'b0, range_end}) && (nx < {1'b0, total_eff});

  assign frac_sum  = {1'b0, cursor_frac} + {1'b0, speed_eff};
  assign carry     = frac_sum >= FRAC_ONE;
  assign frac_wrap = frac_sum - FRAC_ONE;
  assign frac_adv  = carry ? frac_wrap[FRAC_BITS-1:0] : frac_sum[FRAC_BITS-1:0];
  assign whole_adv = (carry && (cursor_whole != CURSOR_MAX)) ? cursor_whole + 17'd1
                                                              : cursor_whole;
  assign whole_after = playing ? whole_adv : cursor_whole;
  assign snap_a      = (whole_after > range_end) ? range_end : whole_after;

  assign end_clamped = (end_position > total_eff) ? total_eff : end_position;
  assign play_ok     = (start_position < total_eff) && (end_clamped > start_position);

  assign fl16 = cursor_whole[FRAME_BITS-1:0];

  always_comb begin
    wr.we    = acc && (opcode == OP_WRITE);
    wr.frame = frame_index;
    wr.chan  = channel_index;
    wr.value = sample_value;

    rd.re        = acc && (opcode == OP_TICK);
    rd.odd_addr  = fl16[FRAME_BITS-1:1];
    rd.even_addr = fl16[FRAME_BITS-1:1] + {{(BANK_BITS-1){1'b0}}, fl16[0]};

    tick.active         = playing && !ended;
    tick.use_next       = next_ok;
    tick.fl_odd         = fl16[0];
    tick.src2           = src_chans >= 2'd2;
    tick.out2           = out_chans >= 2'd2;
    tick.frac           = cursor_frac;
    tick.status.reached = playing && ended;
    tick.status.playing = playing && !ended;
    tick.status.snap    = (snap_a > total_eff) ? total_eff : snap_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed        <= SPEED_MAX;
      total        <= '0;
      src_chans    <= 2'd1;
      out_chans    <= 2'd2;
      cursor_whole <= '0;
      cursor_frac  <= '0;
      range_end    <= '0;
      playing      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SPEED:     speed     <= cfg_data[FRAC_BITS-1:0];
          REG_TOTAL:     total     <= cfg_data;
          REG_SRC_CHANS: src_chans <= cfg_data[1:0];
          REG_OUT_CHANS: out_chans <= cfg_data[1:0];
        endcase
      end
      if (acc) begin
        unique case (opcode)
          OP_WRITE: ;
          OP_PLAY: begin
            if (play_ok) begin
              cursor_whole <= start_position;
              cursor_frac  <= '0;
              range_end    <= end_clamped;
              playing      <= 1'b1;
            end
          end
          OP_STOP: playing <= 1'b0;
          OP_TICK: begin
            if (playing) begin
              cursor_whole <= whole_adv;
              cursor_frac  <= frac_adv;
              if (ended) begin
                playing <= 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  `VSSP_ASSERT_NEXT(stop_clears_playing, acc && (opcode == OP_STOP), !playing)
  `VSSP_ASSERT(playing_range_valid, !playing || ((range_end != '0) && (range_end <= TOTAL_MAX)))
  `VSSP_ASSERT(frac_below_one, {1'b0, cursor_frac} < FRAC_ONE)

endmodule

/* hw/rtl/variable_speed_sample_player_unit.sv */
// Variable speed sample player: one voice, linear interpolation from a two-bank sample store.
// A tick request's result is registered in turn through the memory read,
// three interpolator stages and the output register. Throughput: one request per cycle; the
// pipeline holds only while the output register is full and not taken.
// Reset (synchronous, rst high) clears cursor, range and play flag and sets config to its defaults; the store
// keeps its contents and is not cleared.
`include "variable_speed_sample_player_unit_defines.svh"
module variable_speed_sample_player_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_index[15:0], channel_index[16], sample_value[32:17],
  // start_position[49:33], end_position[66:50], zero pad[71:67]
  input  logic [71:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_left[15:0], out_right[31:16], reached_end[32], still_playing[33],
  // cursor_snapshot[50:34], zero pad[55:51]
  output logic [55:0] m_axis_tdata
);
  import vssp_pkg::*;

  logic                     adv;
  logic                     acc;
  vssp_wr_t                 wr;
  vssp_rd_t                 rd;
  vssp_tick_t               tick;
  logic [2*SAMPLE_BITS-1:0] even_q;
  logic [2*SAMPLE_BITS-1:0] odd_q;

  logic         s1_valid, s2_valid, s3_valid, s4_valid;
  vssp_tick_t   s1_tick;
  vssp_status_t s2_status, s3_status, s4_status;

  logic [2*SAMPLE_BITS-1:0]      a_word, n_word, b_word;
  logic signed [SAMPLE_BITS-1:0] left_a, left_b, right_a, right_b;
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;

  assign cfg_ready     = 1'b1;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  vssp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .acc            (acc),
    .opcode         (s_axis_tuser),
    .frame_index    (s_axis_tdata[15:0]),
    .channel_index  (s_axis_tdata[16]),
    .sample_value   ($signed(s_axis_tdata[32:17])),
    .start_position (s_axis_tdata[49:33]),
    .end_position   (s_axis_tdata[66:50]),
    .wr             (wr),
    .rd             (rd),
    .tick           (tick)
  );

  vssp_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .even_q (even_q),
    .odd_q  (odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid      <= acc && (s_axis_tuser == OP_TICK);
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      m_axis_tvalid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tick      <= tick;
      s2_status    <= s1_tick.status;
      s3_status    <= s2_status;
      s4_status    <= s3_status;
      m_axis_tdata <= {5'b0, s4_status.snap, s4_status.playing, s4_status.reached,
                       right_res, left_res};
    end
  end

  // pick floor and next frame words from the banks
  assign a_word = s1_tick.fl_odd ? odd_q : even_q;
  assign n_word = s1_tick.fl_odd ? even_q : odd_q;
  assign b_word = s1_tick.use_next ? n_word : a_word;

  always_comb begin
    left_a  = '0;
    left_b  = '0;
    right_a = '0;
    right_b = '0;
    if (s1_tick.active) begin
      left_a = $signed(a_word[SAMPLE_BITS-1:0]);
      left_b = $signed(b_word[SAMPLE_BITS-1:0]);
      if (s1_tick.out2) begin
        right_a = s1_tick.src2 ? $signed(a_word[2*SAMPLE_BITS-1:SAMPLE_BITS]) : left_a;
        right_b = s1_tick.src2 ? $signed(b_word[2*SAMPLE_BITS-1:SAMPLE_BITS]) : left_b;
      end
    end
  end

  vssp_interp u_interp_left (
    .clk  (clk),
    .en   (adv),
    .a    (left_a),
    .b    (left_b),
    .frac (s1_tick.frac),
    .res  (left_res)
  );

  vssp_interp u_interp_right (
    .clk  (clk),
    .en   (adv),
    .a    (right_a),
    .b    (right_b),
    .frac (s1_tick.frac),
    .res  (right_res)
  );

  `VSSP_ASSERT(end_is_silent, !m_axis_tvalid || !m_axis_tdata[32] || (m_axis_tdata[31:0] == '0))
  `VSSP_ASSERT(end_stops_play, !m_axis_tvalid || !(m_axis_tdata[32] && m_axis_tdata[33]))
  `VSSP_ASSERT(snapshot_in_range, !m_axis_tvalid || (m_axis_tdata[50:34] <= TOTAL_MAX))

endmodule

/* tb/variable_speed_sample_player_unit_test.sv */
// Self-checking bench for variable_speed_sample_player_unit: stream requests in, frames out.
// Predicts each output frame with its own voice model; depends on vssp_pkg and the unit.
module variable_speed_sample_player_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vssp_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 180;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               reached;
    logic               playing;
    logic [16:0]        snap;
  } voice_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SPEED;
  logic [16:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_STOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [55:0] m_axis_tdata;

  variable_speed_sample_player_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk = ~clk;

  // voice model state
  logic signed [15:0] sample_mem [65536][2];
  bit [1:0]           loaded [65536];
  logic [16:0]        cur_whole = '0;
  logic [10:0]        cur_frac = '0;
  logic [16:0]        stop_at = '0;
  logic               voice_playing = 1'b0;
  logic [9:0]         speed_reg = SPEED_MAX;
  logic [16:0]        total_reg = '0;
  logic [1:0]         src_reg = 2'd1;
  logic [1:0]         out_reg = 2'd2;

  voice_frame_t pending_frames [$];
  int  errors = 0;
  int  cycle_count = 0;
  int  sink_wait = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;
  int  win_lo [2];
  int  win_hi [2];

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [16:0] any17();
    return 17'($urandom);
  endfunction

  function automatic logic [16:0] eff_total();
    return (total_reg > TOTAL_MAX) ? TOTAL_MAX : total_reg;
  endfunction

  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic [10:0] f);
    longint num;
    num = longint'(FRAC_ONE - f) * longint'(a) + longint'(f) * longint'(b);
    if (num >= 0) return 16'((num + 500) / 1000);
    return 16'(-((-num + 500) / 1000));
  endfunction

  function automatic bit span_loaded(input int first, input int last_excl);
    for (int fr = first; fr < last_excl && fr < 65536; fr++)
      if (loaded[fr] != 2'b11) return 1'b0;
    return 1'b1;
  endfunction

  task automatic step_voice(input logic [1:0] op, input logic [15:0] frame, input logic chan,
                            input logic signed [15:0] sample, input logic [16:0] start,
                            input logic [16:0] fin);
    logic [16:0]  total;
    logic [16:0]  limit;
    logic [16:0]  nxt;
    logic [16:0]  rd_b;
    logic [10:0]  speed;
    logic         ended;
    voice_frame_t res;
    total = eff_total();
    speed = (speed_reg < SPEED_MIN) ? SPEED_MIN : (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
    case (op)
      OP_WRITE: begin
        sample_mem[frame][chan] = sample;
        loaded[frame][chan] = 1'b1;
      end
      OP_PLAY: begin
        limit = (fin > total) ? total : fin;
        if (start < total && limit > start) begin
          cur_whole = start;
          cur_frac = '0;
          stop_at = limit;
          voice_playing = 1'b1;
        end
      end
      OP_STOP: voice_playing = 1'b0;
      OP_TICK: begin
        res = '0;
        ended = 1'b0;
        if (voice_playing) begin
          if (cur_whole >= stop_at || cur_whole >= total) begin
            ended = 1'b1;
          end else begin
            nxt = cur_whole + 17'd1;
            rd_b = (nxt < stop_at && nxt < total) ? nxt : cur_whole;
            res.left = blend(sample_mem[cur_whole[15:0]][0], sample_mem[rd_b[15:0]][0], cur_frac);
            if (out_reg >= 2'd2)
              res.right = (src_reg >= 2'd2) ?
                  blend(sample_mem[cur_whole[15:0]][1], sample_mem[rd_b[15:0]][1], cur_frac) :
                  res.left;
          end
          cur_frac = cur_frac + speed;
          if (cur_frac >= FRAC_ONE) begin
            cur_frac = cur_frac - FRAC_ONE;
            if (cur_whole < CURSOR_MAX) cur_whole = cur_whole + 17'd1;
          end
          if (ended) voice_playing = 1'b0;
        end
        res.reached = ended;
        res.playing = voice_playing;
        res.snap = cur_whole;
        if (res.snap > stop_at) res.snap = stop_at;
        if (res.snap > total) res.snap = total;
        pending_frames.push_back(res);
      end
    endcase
  endtask

  always @(posedge clk) begin : result_check
    voice_frame_t want;
    int stall;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected output frame %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (m_axis_tdata[15:0] !== want.left) begin
          $error("out_left expected %0d got %0d", want.left, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== want.right) begin
          $error("out_right expected %0d got %0d", want.right, $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[32] !== want.reached) begin
          $error("reached_end expected %0d got %0d", want.reached, m_axis_tdata[32]);
          errors++;
        end
        if (m_axis_tdata[33] !== want.playing) begin
          $error("still_playing expected %0d got %0d", want.playing, m_axis_tdata[33]);
          errors++;
        end
        if (m_axis_tdata[50:34] !== want.snap) begin
          $error("cursor_snapshot expected %0d got %0d", want.snap, m_axis_tdata[50:34]);
          errors++;
        end
      end
      stall = sink_idle ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait = stall;
      end
    end else if (sink_wait != 0) begin
      sink_wait = sink_wait - 1;
      if (sink_wait == 0) m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] frame, input logic chan,
                              input logic signed [15:0] sample, input logic [16:0] start,
                              input logic [16:0] fin);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'd0, fin, start, sample, chan, frame};
    do @(posedge clk); while (!s_axis_tready);
    step_voice(op, frame, chan, sample, start, fin);
  endtask

  task automatic send_write(input int frame, input int chan, input logic signed [15:0] sample);
    send_request(OP_WRITE, 16'(frame), chan[0], sample, any17(), any17());
  endtask

  task automatic send_play(input logic [16:0] start, input logic [16:0] fin);
    send_request(OP_PLAY, 16'($urandom), 1'($urandom), 16'($urandom), start, fin);
  endtask

  task automatic send_stop();
    send_request(OP_STOP, 16'($urandom), 1'($urandom), 16'($urandom), any17(), any17());
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 16'($urandom), 1'($urandom), 16'($urandom), any17(), any17());
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_tick();
  endtask

  task automatic drain_results(input bit settle);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [16:0] speed, input logic [16:0] total,
                           input logic [16:0] src, input logic [16:0] outc);
    logic [16:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{speed, total, src, outc};
    idx = '{REG_SPEED, REG_TOTAL, REG_SRC_CHANS, REG_OUT_CHANS};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_SPEED:     speed_reg = vals[i][9:0];
        REG_TOTAL:     total_reg = vals[i];
        REG_SRC_CHANS: src_reg = vals[i][1:0];
        REG_OUT_CHANS: out_reg = vals[i][1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_span(input int lo, input int hi);
    for (int fr = lo; fr < hi && fr < 65536; fr++)
      for (int ch = 0; ch < 2; ch++)
        if (!loaded[fr][ch]) send_write(fr, ch, 16'($urandom));
  endtask

  task automatic test_idle_after_reset();
    send_ticks(3);
    send_play(17'd0, 17'd5);
    send_tick();
    send_stop();
    send_tick();
  endtask

  task automatic test_directed_cases();
    drain_results(1'b1);
    configure(17'd1000, 17'd4, 17'd2, 17'd2);
    send_write(0, 0, 16'sh7FFF);
    send_write(0, 1, 16'sh8000);
    send_write(1, 0, 16'sh8000);
    send_write(1, 1, 16'sh7FFF);
    send_write(2, 0, 16'sd0);
    send_write(2, 1, -16'sd1);
    send_write(3, 0, 16'sd1);
    send_write(3, 1, 16'sd0);
    send_write(4, 0, -16'sd1);
    send_write(4, 1, 16'sd1);
    send_play(17'd0, 17'd3);
    send_ticks(4);
    drain_results(1'b1);
    configure(17'd500, 17'd4, 17'd2, 17'd2);
    send_play(17'd1, 17'h1FFFF);
    send_ticks(8);
    send_play(17'd4, 17'd10);
    send_play(17'd2, 17'd2);
    send_tick();
    send_play(17'd0, 17'd4);
    send_tick();
    send_stop();
    send_tick();
    drain_results(1'b1);
    configure(17'd1000, 17'd4, 17'd1, 17'd1);
    send_play(17'd0, 17'd4);
    send_ticks(2);
    send_stop();
  endtask

  task automatic test_random_playback();
    logic [16:0] sp [9];
    logic [16:0] tot [9];
    logic [16:0] sc [9];
    logic [16:0] oc [9];
    logic [16:0] start;
    logic [16:0] fin;
    logic [16:0] limit;
    int total;
    int base;
    int hi_end;
    int w;
    int pick;
    sp  = '{1000, 100, 0, 1023, $urandom_range(100, 1000), $urandom_range(100, 1000),
            $urandom_range(0, 1023), 1, $urandom_range(0, 1023)};
    tot = '{64, 64, 33, 17, 131071, 65536, $urandom_range(1, 200), 1, 65535};
    sc  = '{2, 1, 2, 3, 2, 0, $urandom_range(0, 3), 2, 2};
    oc  = '{2, 2, 1, 3, 2, 0, $urandom_range(0, 3), 2, 2};
    for (int ph = 0; ph < 9; ph++) begin
      drain_results(1'b1);
      configure(sp[ph], tot[ph], sc[ph], oc[ph]);
      total = eff_total();
      if (total <= 256) begin
        win_lo = '{0, 0};
        win_hi = '{total + 1, total + 1};
      end else begin
        base = $urandom_range(0, 60000);
        win_lo = '{base, 65504};
        win_hi = '{base + 32, 65536};
      end
      load_span(win_lo[0], win_hi[0]);
      load_span(win_lo[1], win_hi[1]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          src_idle = ($urandom_range(0, 2) != 0);
          sink_idle = ($urandom_range(0, 2) != 0);
        end
        if (n % 64 == 63) drain_results(1'b0);
        pick = $urandom_range(0, 99);
        w = $urandom_range(0, 1);
        if (pick < 55) begin
          send_tick();
        end else if (pick < 75 && pick >= 70) begin
          send_stop();
        end else if (pick >= 75 && pick < 87) begin
          if ($urandom_range(0, 1) != 0)
            send_write($urandom_range(0, 65535), $urandom_range(0, 1), 16'($urandom));
          else
            send_write($urandom_range(win_lo[w], win_hi[w] - 1), $urandom_range(0, 1),
                       16'($urandom));
        end else begin
          start = any17();
          fin = any17();
          if (pick < 70) begin
            hi_end = (win_hi[w] == 65536) ? 65536 : win_hi[w] - 1;
            if (hi_end > total) hi_end = total;
            if (hi_end > win_lo[w]) begin
              start = 17'($urandom_range(win_lo[w], hi_end - 1));
              fin = 17'($urandom_range(int'(start) + 1, hi_end));
              if (hi_end == total && $urandom_range(0, 3) == 0)
                fin = 17'($urandom_range(total, 131071));
            end
          end
          limit = (fin > eff_total()) ? eff_total() : fin;
          if (start < eff_total() && limit > start && !span_loaded(start, int'(limit) + 1))
            send_tick();
          else
            send_play(start, fin);
        end
      end
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_idle_after_reset();
    test_directed_cases();
    test_random_playback();
    drain_results(1'b1);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
